/* hdl/uer_pkg.sv */
// package for the ultrasonic echo ranging block
// types and constants shared by the top level; no dependencies
`default_nettype none
package uer_pkg;
  localparam int MAX_ATTEMPTS_DEF = 100;
  localparam int STORE_DEPTH_DEF = 128;
  localparam logic [6:0] ROUNDS_CAP = 7'd100;
  localparam logic [6:0] COUNT_CAP = 7'd127;

  localparam logic [2:0] REG_ROUNDS = 3'd0;
  localparam logic [2:0] REG_SETTLE = 3'd1;
  localparam logic [2:0] REG_TRIG = 3'd2;
  localparam logic [2:0] REG_ARM = 3'd3;
  localparam logic [2:0] REG_ECHO = 3'd4;

  typedef enum logic [2:0] {
    PH_IDLE, PH_SETTLE, PH_SHOT, PH_ARM, PH_HIGH
  } phase_t;

  typedef enum logic [2:0] {
    SQ_WAIT, SQ_SHIFT, SQ_PLACE, SQ_MEDRD, SQ_MEDGET, SQ_OUT
  } seq_t;
endpackage
`default_nettype wire

/* hdl/ultrasonic_echo_ranging.sv */
// ultrasonic echo ranging controller, top level
// uses uer_pkg; holds the sorted width store as an internal memory
//
// each input transaction is one microsecond tick carrying start_req and
// echo_level; each tick yields exactly one output transaction with the
// trigger level, busy flag and, on the finishing tick, the result.
// a tick is taken when in_valid is high and in_stall low; in_stall is high
// while a tick is being worked on or its result has not been taken.
// an ordinary tick raises out_valid in the cycle after acceptance; a tick
// that stores an echo width runs a sorted insertion, moving one store entry
// per cycle until the new width is in place; a finishing tick with samples
// then reads the median entry through the SQ_MEDRD and SQ_MEDGET states.
// the result stays in the output register until out_stall is low; no new tick
// is taken meanwhile. configuration is written through cfg_we, cfg_index and
// cfg_data; the user must do so only while idle, the block does not enforce
// it. reset (rst, synchronous) returns the block to idle with default register
// values; the store needs no clearing since only written entries are read.
`default_nettype none
module ultrasonic_echo_ranging #(
  parameter int MAX_ATTEMPTS = uer_pkg::MAX_ATTEMPTS_DEF,
  parameter int STORE_DEPTH = uer_pkg::STORE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        start_req,
  input  wire logic        echo_level,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             trigger_level,
  output logic             busy_res,
  output logic             result_valid,
  output logic             failed,
  output logic [15:0]      median_width,
  output logic [6:0]       samples_taken,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam logic [8:0] DEPTH9 = 9'(STORE_DEPTH);
  localparam logic [6:0] MAXA = 7'(MAX_ATTEMPTS);

  logic [6:0] rounds;
  logic [15:0] settle_time, arm_timeout, echo_timeout;
  logic [7:0] trigger_width;

  uer_pkg::phase_t phase, phase_next;
  uer_pkg::seq_t seq, seq_next;
  logic [15:0] phase_timer, phase_timer_next;
  logic [6:0] attempt_count, attempt_count_next;
  logic [6:0] sample_count, sample_count_next;

  logic [15:0] mem [STORE_DEPTH];
  logic [15:0] rd_data;
  logic [6:0] k;
  logic [15:0] ins_w;
  logic done_r;
  logic trig_r, busy_r;
  logic [6:0] rcl;
  logic do_ins, done_c, trig_c, busy_c, stop_c;
  logic [15:0] ins_c;
  logic [6:0] att_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      rounds <= 7'd1;
      settle_time <= 16'd5000;
      trigger_width <= 8'd10;
      arm_timeout <= 16'd5000;
      echo_timeout <= 16'd60000;
    end else if (cfg_we) begin
      case (cfg_index)
        uer_pkg::REG_ROUNDS: rounds <= cfg_data[6:0];
        uer_pkg::REG_SETTLE: settle_time <= cfg_data;
        uer_pkg::REG_TRIG:   trigger_width <= cfg_data[7:0];
        uer_pkg::REG_ARM:    arm_timeout <= cfg_data;
        uer_pkg::REG_ECHO:   echo_timeout <= cfg_data;
        default: ;
      endcase
    end
  end

  assign rcl = (rounds == 7'd0) ? 7'd1 :
               (rounds > uer_pkg::ROUNDS_CAP) ? uer_pkg::ROUNDS_CAP : rounds;
  assign att_inc = attempt_count + 7'd1;
  assign stop_c = (att_inc > MAXA) || ((att_inc > rcl) && (sample_count_next > (rcl >> 1)));

  // tick evaluation
  always_comb begin
    uer_pkg::phase_t p;
    logic end_att;
    p = phase;
    phase_timer_next = phase_timer;
    attempt_count_next = attempt_count;
    sample_count_next = sample_count;
    busy_c = 1'b1;
    trig_c = 1'b0;
    do_ins = 1'b0;
    ins_c = phase_timer;
    end_att = 1'b0;
    if (phase == uer_pkg::PH_IDLE) begin
      if (start_req) begin
        p = uer_pkg::PH_SETTLE;
        phase_timer_next = 16'd0;
        attempt_count_next = 7'd0;
        sample_count_next = 7'd0;
      end else begin
        busy_c = 1'b0;
      end
    end
    phase_next = p;
    case (p)
      uer_pkg::PH_SETTLE: begin
        phase_timer_next = phase_timer_next + 16'd1;
        if (phase_timer_next >= settle_time) begin
          phase_next = uer_pkg::PH_SHOT;
          phase_timer_next = 16'd0;
        end
      end
      uer_pkg::PH_SHOT: begin
        trig_c = 1'b1;
        phase_timer_next = phase_timer + 16'd1;
        if (phase_timer_next >= {8'd0, trigger_width}) begin
          phase_next = uer_pkg::PH_ARM;
          phase_timer_next = 16'd0;
        end
      end
      uer_pkg::PH_ARM: begin
        if (echo_level) begin
          phase_next = uer_pkg::PH_HIGH;
          phase_timer_next = 16'd0;
        end else begin
          phase_timer_next = phase_timer + 16'd1;
          end_att = (phase_timer_next >= arm_timeout);
        end
      end
      uer_pkg::PH_HIGH: begin
        if (!echo_level) begin
          if (phase_timer != 16'd0 && {2'b0, sample_count} < DEPTH9 &&
              sample_count < uer_pkg::COUNT_CAP) begin
            do_ins = 1'b1;
            sample_count_next = sample_count + 7'd1;
          end
          end_att = 1'b1;
        end else begin
          phase_timer_next = phase_timer + 16'd1;
          end_att = (phase_timer_next >= echo_timeout);
        end
      end
      default: phase_next = uer_pkg::PH_IDLE;
    endcase
    done_c = 1'b0;
    if (end_att) begin
      attempt_count_next = att_inc;
      phase_timer_next = 16'd0;
      done_c = stop_c;
      phase_next = stop_c ? uer_pkg::PH_IDLE : uer_pkg::PH_SETTLE;
    end
  end

  always_comb begin
    seq_next = seq;
    case (seq)
      uer_pkg::SQ_WAIT:
        if (in_valid) begin
          if (do_ins) seq_next = uer_pkg::SQ_SHIFT;
          else if (done_c && sample_count_next != 7'd0) seq_next = uer_pkg::SQ_MEDRD;
          else seq_next = uer_pkg::SQ_OUT;
        end
      uer_pkg::SQ_SHIFT:
        if (k == 7'd0 || rd_data <= ins_w) seq_next = uer_pkg::SQ_PLACE;
      uer_pkg::SQ_PLACE:
        seq_next = done_r ? uer_pkg::SQ_MEDRD : uer_pkg::SQ_OUT;
      uer_pkg::SQ_MEDRD: seq_next = uer_pkg::SQ_MEDGET;
      uer_pkg::SQ_MEDGET: seq_next = uer_pkg::SQ_OUT;
      uer_pkg::SQ_OUT: if (!out_stall) seq_next = uer_pkg::SQ_WAIT;
      default: seq_next = uer_pkg::SQ_WAIT;
    endcase
  end

  assign in_stall = (seq != uer_pkg::SQ_WAIT);
  assign out_valid = (seq == uer_pkg::SQ_OUT);
  assign trigger_level = trig_r;
  assign busy_res = busy_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= uer_pkg::SQ_WAIT;
      phase <= uer_pkg::PH_IDLE;
      phase_timer <= 16'd0;
      attempt_count <= 7'd0;
      sample_count <= 7'd0;
    end else begin
      seq <= seq_next;
      if (seq == uer_pkg::SQ_WAIT && in_valid) begin
        phase <= phase_next;
        phase_timer <= phase_timer_next;
        attempt_count <= attempt_count_next;
        sample_count <= sample_count_next;
      end
    end
  end

  // insertion walks k down from the old count; rd_data holds mem[k-1]
  always_ff @(posedge clk) begin
    case (seq)
      uer_pkg::SQ_WAIT: if (in_valid) begin
        trig_r <= trig_c;
        busy_r <= busy_c;
        done_r <= done_c;
        ins_w <= ins_c;
        k <= sample_count;
        result_valid <= done_c;
        failed <= done_c && (sample_count_next == 7'd0);
        samples_taken <= done_c ? sample_count_next : 7'd0;
        median_width <= 16'd0;
        if (sample_count != 7'd0) rd_data <= mem[AW'(sample_count - 7'd1)];
      end
      uer_pkg::SQ_SHIFT: begin
        if (k != 7'd0 && rd_data > ins_w) begin
          mem[AW'(k)] <= rd_data;
          k <= k - 7'd1;
          if (k > 7'd1) rd_data <= mem[AW'(k - 7'd2)];
          else rd_data <= 16'd0;
        end else begin
          mem[AW'(k)] <= ins_w;
          k <= 7'd0;
        end
      end
      uer_pkg::SQ_MEDRD: rd_data <= mem[AW'(sample_count >> 1)];
      uer_pkg::SQ_MEDGET: median_width <= rd_data;
      default: ;
    endcase
  end
endmodule
`default_nettype wire
